[rtl/scel_pkg.sv]
`default_nettype none

package scel_pkg;

    localparam int SOURCE_COUNT = 5;
    localparam int SRC_W        = 3;
    localparam int TIME_W       = 32;
    localparam int OUT_SLOT_W   = 5;
    localparam int LOG_DEPTH_DEF = 32;

    // One tick as seen by the merge stage: which lanes saw a change,
    // the new levels and the time stamp of the tick.
    typedef struct packed {
        logic [SOURCE_COUNT-1:0] changed;
        logic [SOURCE_COUNT-1:0] levels;
        logic [TIME_W-1:0]       stamp;
    } scel_tick_t;

    // Layout of one log record: time, source, level.
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [SRC_W-1:0]  source;
        logic              level;
    } scel_rec_t;

endpackage

`default_nettype wire

[rtl/scel_lane.sv]
`default_nettype none

module scel_lane
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire logic cur_level,
    output logic      changed
);

    logic prev_reg;
    logic prev_next;

    // The remembered level follows the input only on an accepted beat.
    always_comb
    begin
        prev_next = load ? cur_level : prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

    assign changed = cur_level ^ prev_reg;

endmodule

`default_nettype wire

[rtl/scel_merge.sv]
`default_nettype none

module scel_merge
#(
    parameter int LOG_DEPTH = scel_pkg::LOG_DEPTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            tick_valid,
    input  wire scel_pkg::scel_tick_t            tick,
    output logic                                 busy,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [scel_pkg::SRC_W-1:0]           source_id,
    output logic                                 new_level,
    output logic [scel_pkg::TIME_W-1:0]          stamp_seconds,
    output logic [scel_pkg::OUT_SLOT_W-1:0]      slot_index,
    output logic                                 last_in_run
);

    import scel_pkg::*;

    localparam int SLOT_W = $clog2(LOG_DEPTH);

    logic [SOURCE_COUNT-1:0] mask_reg;
    logic [SOURCE_COUNT-1:0] mask_next;
    logic [SOURCE_COUNT-1:0] levels_reg;
    logic [TIME_W-1:0]       stamp_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [SLOT_W-1:0]       slot_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SRC_W-1:0]        src_out_reg;
    logic                    level_out_reg;
    logic [TIME_W-1:0]       stamp_out_reg;
    logic [SLOT_W-1:0]       slot_out_reg;
    logic                    last_out_reg;

    logic [SRC_W-1:0]        sel_idx;
    logic                    sel_found;
    logic [SOURCE_COUNT-1:0] rest;
    logic                    pop;
    logic                    accept;
    logic [SLOT_W+OUT_SLOT_W-1:0] slot_wide;
    scel_rec_t               rec;

    scel_rec_t event_log [LOG_DEPTH];

    // Lowest pending source goes first.
    always_comb
    begin
        sel_idx   = '0;
        sel_found = 1'b0;
        for (int i = 0; i < SOURCE_COUNT; i++)
        begin
            if (mask_reg[i] && !sel_found)
            begin
                sel_idx   = SRC_W'(i);
                sel_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        rest   = mask_reg & ~(SOURCE_COUNT'(1) << sel_idx);
        pop    = (mask_reg != '0) && (!out_valid_reg || !out_stall);
        // A new tick may enter while the last record of the current one leaves.
        busy   = !((mask_reg == '0) || (pop && (rest == '0)));
        accept = tick_valid && !busy;
    end

    always_comb
    begin
        if (accept)
        begin
            mask_next = tick.changed;
        end
        else if (pop)
        begin
            mask_next = rest;
        end
        else
        begin
            mask_next = mask_reg;
        end

        if (pop)
        begin
            slot_next = (slot_reg == SLOT_W'(LOG_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
        end
        else
        begin
            slot_next = slot_reg;
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_comb
    begin
        rec.stamp  = stamp_reg;
        rec.source = sel_idx;
        rec.level  = levels_reg[sel_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg <= tick.levels;
            stamp_reg  <= tick.stamp;
        end
        if (pop)
        begin
            src_out_reg   <= rec.source;
            level_out_reg <= rec.level;
            stamp_out_reg <= rec.stamp;
            slot_out_reg  <= slot_reg;
            last_out_reg  <= (rest == '0);
            event_log[slot_reg] <= rec;
        end
    end

    assign slot_wide     = {{OUT_SLOT_W{1'b0}}, slot_out_reg};
    assign out_valid     = out_valid_reg;
    assign source_id     = src_out_reg;
    assign new_level     = level_out_reg;
    assign stamp_seconds = stamp_out_reg;
    assign slot_index    = slot_wide[OUT_SLOT_W-1:0];
    assign last_in_run   = last_out_reg;

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(LOG_DEPTH - 1))
        else $error("write slot beyond log depth");

    a_slot_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> $stable(slot_reg))
        else $error("write slot moved without a record");

    a_hold_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(mask_reg) > 1) |-> busy)
        else $error("new tick taken while several records pending");

    a_pop_drains_one: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !accept) |=> ($countones(mask_reg) == $past($countones(mask_reg)) - 1))
        else $error("record pop did not clear exactly one source");

endmodule

`default_nettype wire

[rtl/state_change_event_logger.sv]
`default_nettype none

// Change-of-state logger for five monitored signals. Every accepted input beat
// carries the current signal levels and a seconds time stamp; five lanes
// compare each level with the one held from the previous beat. Each change,
// in source order 0 to 4, is written to a ring log of LOG_DEPTH records and
// leaves as one output beat with its slot number; last_in_run marks the final
// beat of a tick. Output beats leave at one per cycle from the merge stage while
// out_stall is low; a tick with no changes gives no output beat, and the next
// tick is taken in the same cycle as the last record of the current one. After
// reset all signals count as off and the log starts at slot 0.
module state_change_event_logger
#(
    parameter int LOG_DEPTH = scel_pkg::LOG_DEPTH_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [scel_pkg::SOURCE_COUNT-1:0]   signal_levels,
    input  wire logic [scel_pkg::TIME_W-1:0]         event_time,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [scel_pkg::SRC_W-1:0]               source_id,
    output logic                                     new_level,
    output logic [scel_pkg::TIME_W-1:0]              stamp_seconds,
    output logic [scel_pkg::OUT_SLOT_W-1:0]          slot_index,
    output logic                                     last_in_run
);

    import scel_pkg::*;

    logic                    accept;
    logic                    busy;
    logic [SOURCE_COUNT-1:0] changed;
    scel_tick_t              tick;

    assign accept   = in_valid && !busy;
    assign in_stall = busy;

    for (genvar g = 0; g < SOURCE_COUNT; g++)
    begin : g_lane
        scel_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (accept),
            .cur_level (signal_levels[g]),
            .changed   (changed[g])
        );
    end

    always_comb
    begin
        tick.changed = changed;
        tick.levels  = signal_levels;
        tick.stamp   = event_time;
    end

    scel_merge #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (in_valid),
        .tick          (tick),
        .busy          (busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .source_id     (source_id),
        .new_level     (new_level),
        .stamp_seconds (stamp_seconds),
        .slot_index    (slot_index),
        .last_in_run   (last_in_run)
    );

endmodule

`default_nettype wire
